// ===== rtl/ps2s1_pkg.sv =====
// Shared types, scan codes and key maps for the scan code set 1 translator.
// Depends on nothing; used by ps2s1_xlate and ps2_scancode_set1_to_ascii.
`default_nettype none

package ps2s1_pkg;

    // Modifier state: bits 0..5 leave the block as flags, bit 6 is the E0 escape.
    localparam int unsigned MOD_W   = 7;
    localparam int unsigned FLAG_W  = 6;
    localparam int unsigned BIT_SHIFT  = 0;
    localparam int unsigned BIT_CTRL   = 1;
    localparam int unsigned BIT_ALT    = 2;
    localparam int unsigned BIT_CAPS   = 3;
    localparam int unsigned BIT_NUM    = 4;
    localparam int unsigned BIT_SCROLL = 5;
    localparam int unsigned BIT_ESC    = 6;

    typedef logic [MOD_W-1:0] t_mod_state;

    // Result of translating one byte
    typedef struct packed {
        logic [7:0] char_code;
        t_mod_state next_state;
    } t_xlate_res;

    // Prefix and modifier scan codes (escaped codes carry bit 7)
    localparam logic [7:0] SC_PREFIX  = 8'hE0;
    localparam logic [7:0] SC_LCTRL   = 8'h1D;
    localparam logic [7:0] SC_RCTRL   = 8'h9D;
    localparam logic [7:0] SC_LSHIFT  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT  = 8'h36;
    localparam logic [7:0] SC_LALT    = 8'h38;
    localparam logic [7:0] SC_RALT    = 8'hB8;
    localparam logic [7:0] SC_CAPS    = 8'h3A;
    localparam logic [7:0] SC_NUM     = 8'h45;
    localparam logic [7:0] SC_SCROLL  = 8'h46;

    // Escaped keys
    localparam logic [7:0] SC_KP_ENTER = 8'h9C;
    localparam logic [7:0] SC_KP_DIV   = 8'hB5;
    localparam logic [7:0] SC_HOME     = 8'hC7;
    localparam logic [7:0] SC_END      = 8'hCF;
    localparam logic [7:0] SC_UP       = 8'hC8;
    localparam logic [7:0] SC_DOWN     = 8'hD0;
    localparam logic [7:0] SC_LEFT     = 8'hCB;
    localparam logic [7:0] SC_RIGHT    = 8'hCD;
    localparam logic [7:0] SC_PGUP     = 8'hC9;
    localparam logic [7:0] SC_PGDN     = 8'hD1;
    localparam logic [7:0] SC_INS      = 8'hD2;
    localparam logic [7:0] SC_DEL      = 8'hD3;

    // Character codes for special keys
    localparam logic [7:0] CH_NONE     = 8'h00;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_CTRL_SL  = 8'hEF;
    localparam logic [7:0] CH_HOME     = 8'hE0;
    localparam logic [7:0] CH_END      = 8'hE1;
    localparam logic [7:0] CH_UP       = 8'hE2;
    localparam logic [7:0] CH_DOWN     = 8'hE3;
    localparam logic [7:0] CH_LEFT     = 8'hE4;
    localparam logic [7:0] CH_RIGHT    = 8'hE5;
    localparam logic [7:0] CH_PGUP     = 8'hE6;
    localparam logic [7:0] CH_PGDN     = 8'hE7;
    localparam logic [7:0] CH_INS      = 8'hE8;
    localparam logic [7:0] CH_DEL      = 8'hE9;
    localparam logic [7:0] CASE_DELTA  = 8'h20;

    localparam int unsigned MAP_DEPTH  = 96;
    localparam int unsigned CTRL_DEPTH = 56;

    // Unshifted map
    localparam logic [7:0] PLAIN_MAP [MAP_DEPTH] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // Shifted map
    localparam logic [7:0] SHIFT_MAP [MAP_DEPTH] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // Control map, covers the low codes only
    localparam logic [7:0] CTRL_MAP [CTRL_DEPTH] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h11, 8'h17, 8'h05, 8'h12, 8'h14, 8'h19, 8'h15, 8'h09,
        8'h0F, 8'h10, 8'h00, 8'h00, 8'h0D, 8'h00, 8'h01, 8'h13,
        8'h04, 8'h06, 8'h07, 8'h08, 8'h0A, 8'h0B, 8'h0C, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h1C, 8'h1A, 8'h18, 8'h03, 8'h16,
        8'h02, 8'h0E, 8'h0D, 8'h00, 8'h00, 8'hEF, 8'h00, 8'h00
    };

    // Held modifier that a code drives
    function automatic t_mod_state hold_mask(input logic [7:0] code);
        t_mod_state m;
        m = '0;
        case (code)
            SC_LCTRL, SC_RCTRL:   m[BIT_CTRL]  = 1'b1;
            SC_LSHIFT, SC_RSHIFT: m[BIT_SHIFT] = 1'b1;
            SC_LALT, SC_RALT:     m[BIT_ALT]   = 1'b1;
            default:              m = '0;
        endcase
        return m;
    endfunction

    // Lock bit that a press toggles
    function automatic t_mod_state lock_mask(input logic [7:0] code);
        t_mod_state m;
        m = '0;
        case (code)
            SC_CAPS:   m[BIT_CAPS]   = 1'b1;
            SC_NUM:    m[BIT_NUM]    = 1'b1;
            SC_SCROLL: m[BIT_SCROLL] = 1'b1;
            default:   m = '0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ps2s1_xlate.sv =====
// Combinational translation of one scan byte against the current modifier state.
// Depends on ps2s1_pkg (maps, scan codes, state layout).
`default_nettype none

module ps2s1_xlate (
    input  wire logic [7:0]            i_scan_byte,
    input  wire ps2s1_pkg::t_mod_state i_state,
    output ps2s1_pkg::t_xlate_res      o_res
);

    logic                  esc;
    logic [7:0]            rel_code;
    logic [7:0]            press_code;
    ps2s1_pkg::t_mod_state press_state;
    logic [7:0]            map_char;
    logic [7:0]            press_char;

    assign esc        = i_state[ps2s1_pkg::BIT_ESC];
    // release keeps bit 7 only when escaped; a press gains bit 7 when escaped
    assign rel_code   = esc ? i_scan_byte : {1'b0, i_scan_byte[6:0]};
    assign press_code = {esc, i_scan_byte[6:0]};

    // Modifier update for a press, escape cleared
    always_comb begin
        press_state = i_state;
        press_state[ps2s1_pkg::BIT_ESC] = 1'b0;
        press_state = press_state | ps2s1_pkg::hold_mask(press_code);
        press_state = press_state ^ ps2s1_pkg::lock_mask(press_code);
    end

    // Map lookup: ctrl wins over shift
    always_comb begin
        map_char = ps2s1_pkg::CH_NONE;
        if (!press_code[7]) begin
            if (press_state[ps2s1_pkg::BIT_CTRL]) begin
                if (press_code < 8'(ps2s1_pkg::CTRL_DEPTH)) begin
                    map_char = ps2s1_pkg::CTRL_MAP[press_code[5:0]];
                end
            end else if (press_code < 8'(ps2s1_pkg::MAP_DEPTH)) begin
                if (press_state[ps2s1_pkg::BIT_SHIFT]) begin
                    map_char = ps2s1_pkg::SHIFT_MAP[press_code[6:0]];
                end else begin
                    map_char = ps2s1_pkg::PLAIN_MAP[press_code[6:0]];
                end
            end
        end else begin
            case (press_code)
                ps2s1_pkg::SC_KP_ENTER: begin
                    map_char = press_state[ps2s1_pkg::BIT_CTRL] ?
                               ps2s1_pkg::CH_CR : ps2s1_pkg::CH_LF;
                end
                ps2s1_pkg::SC_KP_DIV: begin
                    map_char = press_state[ps2s1_pkg::BIT_CTRL] ?
                               ps2s1_pkg::CH_CTRL_SL : ps2s1_pkg::CH_SLASH;
                end
                ps2s1_pkg::SC_HOME:  map_char = ps2s1_pkg::CH_HOME;
                ps2s1_pkg::SC_END:   map_char = ps2s1_pkg::CH_END;
                ps2s1_pkg::SC_UP:    map_char = ps2s1_pkg::CH_UP;
                ps2s1_pkg::SC_DOWN:  map_char = ps2s1_pkg::CH_DOWN;
                ps2s1_pkg::SC_LEFT:  map_char = ps2s1_pkg::CH_LEFT;
                ps2s1_pkg::SC_RIGHT: map_char = ps2s1_pkg::CH_RIGHT;
                ps2s1_pkg::SC_PGUP:  map_char = ps2s1_pkg::CH_PGUP;
                ps2s1_pkg::SC_PGDN:  map_char = ps2s1_pkg::CH_PGDN;
                ps2s1_pkg::SC_INS:   map_char = ps2s1_pkg::CH_INS;
                ps2s1_pkg::SC_DEL:   map_char = ps2s1_pkg::CH_DEL;
                default:             map_char = ps2s1_pkg::CH_NONE;
            endcase
        end
    end

    // Caps lock swaps letter case
    always_comb begin
        press_char = map_char;
        if (press_state[ps2s1_pkg::BIT_CAPS]) begin
            if (map_char inside {[8'h61:8'h7A]}) begin
                press_char = map_char - ps2s1_pkg::CASE_DELTA;
            end else if (map_char inside {[8'h41:8'h5A]}) begin
                press_char = map_char + ps2s1_pkg::CASE_DELTA;
            end
        end
    end

    // Prefix, release or press
    always_comb begin
        o_res.char_code  = ps2s1_pkg::CH_NONE;
        o_res.next_state = i_state;
        if (i_scan_byte == ps2s1_pkg::SC_PREFIX) begin
            o_res.next_state[ps2s1_pkg::BIT_ESC] = 1'b1;
        end else if (i_scan_byte[7]) begin
            o_res.next_state = i_state & ~ps2s1_pkg::hold_mask(rel_code);
            o_res.next_state[ps2s1_pkg::BIT_ESC] = 1'b0;
        end else begin
            o_res.next_state = press_state;
            o_res.char_code  = press_char;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ps2_scancode_set1_to_ascii.sv =====
// Scan code set 1 to ASCII translator, top level: input register, translation, result register.
// An accepted byte goes through the input register and then the result register.
// Throughput: one byte per cycle unless the master side stalls; modifier state updates per byte.
// Reset (synchronous, i_rst_n low): modifier and escape state cleared, both stages emptied.
// Depends on ps2s1_pkg and ps2s1_xlate.
`default_nettype none

module ps2_scancode_set1_to_ascii (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] scan_byte
    // master side
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata    // [7:0] char_code, [13:8] modifier_flags, [15:14] 0
);

    logic                     r_in_valid;
    logic [7:0]               r_in_byte;
    ps2s1_pkg::t_mod_state    r_mod_state;
    logic                     r_out_valid;
    logic [7:0]               r_out_char;
    logic [ps2s1_pkg::FLAG_W-1:0] r_out_flags;

    logic                     n_in_valid;
    logic                     n_out_valid;
    logic                     adv;
    logic                     in_take;
    ps2s1_pkg::t_xlate_res    xres;

    // Result register frees when empty or taken; input stage moves with it
    assign adv             = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || adv;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    ps2s1_xlate u_xlate (
        .i_scan_byte (r_in_byte),
        .i_state     (r_mod_state),
        .o_res       (xres)
    );

    // Stage valid next values
    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        if (adv) begin
            n_out_valid = r_in_valid;
            n_in_valid  = 1'b0;
        end
        if (in_take) begin
            n_in_valid = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mod_state <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (adv && r_in_valid) begin
                r_mod_state <= xres.next_state;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_s_axis_tdata;
        end
        if (adv && r_in_valid) begin
            r_out_char  <= xres.char_code;
            r_out_flags <= xres.next_state[ps2s1_pkg::FLAG_W-1:0];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_flags, r_out_char};

    // Any non-prefix byte leaves the escape flag clear
    a_esc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_valid && r_in_byte != ps2s1_pkg::SC_PREFIX)
        |=> !r_mod_state[ps2s1_pkg::BIT_ESC])
        else $error("escape flag survived a non-prefix byte");

    // A prefix arms escape and yields no character
    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_valid && r_in_byte == ps2s1_pkg::SC_PREFIX)
        |=> (r_mod_state[ps2s1_pkg::BIT_ESC] && r_out_char == ps2s1_pkg::CH_NONE))
        else $error("prefix byte mishandled");

    // A release yields no character
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_valid && r_in_byte[7] && r_in_byte != ps2s1_pkg::SC_PREFIX)
        |=> r_out_char == ps2s1_pkg::CH_NONE)
        else $error("release byte produced a character");

    // State moves only when a byte is translated
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(adv && r_in_valid) |=> $stable(r_mod_state))
        else $error("modifier state changed without a byte");

endmodule

`default_nettype wire

// ===== sim/ps2_scancode_set1_to_ascii_tb.sv =====
// Self-checking testbench for ps2_scancode_set1_to_ascii: drives scan code bytes with random gaps
// and checks each character/flags transaction against an in-bench translator model.
// Depends on ps2s1_pkg and the ps2_scancode_set1_to_ascii RTL.
module ps2_scancode_set1_to_ascii_tb;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_BYTES = 420;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned DRAIN_CYCLES = 8;

    // Key codes used as data in the stimulus
    localparam logic [7:0] BREAK_FLAG = 8'h80;
    localparam logic [7:0] KEY_A      = 8'h1E;
    localparam logic [7:0] KEY_SLASH  = 8'h35;
    localparam logic [7:0] KEY_LAST   = 8'h7F;

    typedef enum logic [1:0] {MAP_PLAIN, MAP_SHIFT, MAP_CTRL} t_map_sel;

    typedef struct packed {
        logic [7:0] char_code;
        logic [5:0] flags;
    } t_key_result;

    // Character maps, indexed by make code
    localparam logic [7:0] LOWER_KEYS [ps2s1_pkg::MAP_DEPTH] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam logic [7:0] UPPER_KEYS [ps2s1_pkg::MAP_DEPTH] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam logic [7:0] CTRL_KEYS [ps2s1_pkg::CTRL_DEPTH] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h11, 8'h17, 8'h05, 8'h12, 8'h14, 8'h19, 8'h15, 8'h09,
        8'h0F, 8'h10, 8'h00, 8'h00, 8'h0D, 8'h00, 8'h01, 8'h13,
        8'h04, 8'h06, 8'h07, 8'h08, 8'h0A, 8'h0B, 8'h0C, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h1C, 8'h1A, 8'h18, 8'h03, 8'h16,
        8'h02, 8'h0E, 8'h0D, 8'h00, 8'h00, 8'hEF, 8'h00, 8'h00
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data = 8'h00;
    logic        m_ready = 1'b0;
    wire         s_ready;
    wire         m_valid;
    wire [15:0]  m_data;

    logic [7:0]            scan_q [$];          // bytes waiting to be sent
    t_key_result           expected_keys [$];   // translations waiting for their transaction
    ps2s1_pkg::t_mod_state kb_state = '0;       // model copy of modifier and escape state
    int          bytes_sent = 0;
    int          bytes_total = 0;
    int          mismatches = 0;
    int          cycle_count = 0;
    int          tx_gap = 0;
    int          rx_gap = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;

    ps2_scancode_set1_to_ascii dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),    // [7:0] scan_byte
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)     // [7:0] char_code, [13:8] modifier_flags, [15:14] 0
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Held modifiers that a code drives
    function automatic ps2s1_pkg::t_mod_state held_keys(input logic [7:0] code);
        ps2s1_pkg::t_mod_state m;
        m = '0;
        if (code == ps2s1_pkg::SC_LCTRL || code == ps2s1_pkg::SC_RCTRL)
            m[ps2s1_pkg::BIT_CTRL] = 1'b1;
        else if (code == ps2s1_pkg::SC_LSHIFT || code == ps2s1_pkg::SC_RSHIFT)
            m[ps2s1_pkg::BIT_SHIFT] = 1'b1;
        else if (code == ps2s1_pkg::SC_LALT || code == ps2s1_pkg::SC_RALT)
            m[ps2s1_pkg::BIT_ALT] = 1'b1;
        return m;
    endfunction

    // Lock bits that a plain press flips
    function automatic ps2s1_pkg::t_mod_state lock_toggles(input logic [7:0] code);
        ps2s1_pkg::t_mod_state m;
        m = '0;
        if (code == ps2s1_pkg::SC_CAPS)
            m[ps2s1_pkg::BIT_CAPS] = 1'b1;
        else if (code == ps2s1_pkg::SC_NUM)
            m[ps2s1_pkg::BIT_NUM] = 1'b1;
        else if (code == ps2s1_pkg::SC_SCROLL)
            m[ps2s1_pkg::BIT_SCROLL] = 1'b1;
        return m;
    endfunction

    function automatic logic [7:0] key_char(input logic [7:0] code, input t_map_sel sel);
        if (!code[7]) begin
            if (sel == MAP_CTRL) begin
                if (code < 8'(ps2s1_pkg::CTRL_DEPTH))
                    return CTRL_KEYS[code[5:0]];
                return ps2s1_pkg::CH_NONE;
            end
            if (code >= 8'(ps2s1_pkg::MAP_DEPTH))
                return ps2s1_pkg::CH_NONE;
            if (sel == MAP_SHIFT)
                return UPPER_KEYS[code[6:0]];
            return LOWER_KEYS[code[6:0]];
        end
        case (code)
            ps2s1_pkg::SC_KP_ENTER:
                return (sel == MAP_CTRL) ? ps2s1_pkg::CH_CR : ps2s1_pkg::CH_LF;
            ps2s1_pkg::SC_KP_DIV:
                return (sel == MAP_CTRL) ? ps2s1_pkg::CH_CTRL_SL : ps2s1_pkg::CH_SLASH;
            ps2s1_pkg::SC_HOME:  return ps2s1_pkg::CH_HOME;
            ps2s1_pkg::SC_END:   return ps2s1_pkg::CH_END;
            ps2s1_pkg::SC_UP:    return ps2s1_pkg::CH_UP;
            ps2s1_pkg::SC_DOWN:  return ps2s1_pkg::CH_DOWN;
            ps2s1_pkg::SC_LEFT:  return ps2s1_pkg::CH_LEFT;
            ps2s1_pkg::SC_RIGHT: return ps2s1_pkg::CH_RIGHT;
            ps2s1_pkg::SC_PGUP:  return ps2s1_pkg::CH_PGUP;
            ps2s1_pkg::SC_PGDN:  return ps2s1_pkg::CH_PGDN;
            ps2s1_pkg::SC_INS:   return ps2s1_pkg::CH_INS;
            ps2s1_pkg::SC_DEL:   return ps2s1_pkg::CH_DEL;
            default:             return ps2s1_pkg::CH_NONE;
        endcase
    endfunction

    // Translate one accepted byte, advance the model state, queue the expected transaction
    task automatic translate_scan(input logic [7:0] raw);
        logic [7:0]            code;
        logic [7:0]            ch;
        ps2s1_pkg::t_mod_state st;
        t_map_sel              sel;
        t_key_result           res;
        code = raw;
        ch = ps2s1_pkg::CH_NONE;
        st = kb_state;
        if (raw == ps2s1_pkg::SC_PREFIX) begin
            st[ps2s1_pkg::BIT_ESC] = 1'b1;
        end else if (raw[7]) begin
            // release: escaped codes keep bit 7
            if (!st[ps2s1_pkg::BIT_ESC])
                code[7] = 1'b0;
            st = st & ~held_keys(code);
            st[ps2s1_pkg::BIT_ESC] = 1'b0;
        end else begin
            if (st[ps2s1_pkg::BIT_ESC]) begin
                code[7] = 1'b1;
                st[ps2s1_pkg::BIT_ESC] = 1'b0;
            end
            st = st | held_keys(code);
            st = st ^ lock_toggles(code);
            if (st[ps2s1_pkg::BIT_CTRL])
                sel = MAP_CTRL;
            else if (st[ps2s1_pkg::BIT_SHIFT])
                sel = MAP_SHIFT;
            else
                sel = MAP_PLAIN;
            ch = key_char(code, sel);
            // caps lock swaps letter case in whichever map was used
            if (st[ps2s1_pkg::BIT_CAPS]) begin
                if (ch >= "a" && ch <= "z")
                    ch = ch - ps2s1_pkg::CASE_DELTA;
                else if (ch >= "A" && ch <= "Z")
                    ch = ch + ps2s1_pkg::CASE_DELTA;
            end
        end
        kb_state = st;
        res.char_code = ch;
        res.flags = st[ps2s1_pkg::FLAG_W-1:0];
        expected_keys.push_back(res);
    endtask

    task automatic note_mismatch(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch in %s: expected %02h, got %02h", field, want, got);
    endtask

    function automatic int draw_gap(input bit calm);
        if (calm)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    // Press and release of one key, optionally behind the E0 prefix
    task automatic push_key(input logic [7:0] code, input bit escaped);
        if (escaped)
            scan_q.push_back(ps2s1_pkg::SC_PREFIX);
        scan_q.push_back(code);
        if (escaped)
            scan_q.push_back(ps2s1_pkg::SC_PREFIX);
        scan_q.push_back(code | BREAK_FLAG);
    endtask

    // Driver: one byte per transaction, random gap after each
    always @(posedge clk) begin
        if (!rst_n) begin
            s_valid <= 1'b0;
            tx_gap <= draw_gap(1'b0);
        end else begin
            if (s_valid && s_ready) begin
                translate_scan(s_data);
                bytes_sent++;
            end
            if (!s_valid || s_ready) begin
                if (tx_gap != 0) begin
                    s_valid <= 1'b0;
                    tx_gap <= tx_gap - 1;
                end else if (scan_q.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data <= scan_q.pop_front();
                    tx_gap <= draw_gap(tx_calm);
                    if ($urandom_range(0, 39) == 0)
                        tx_calm <= !tx_calm;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random stalls on ready, field-by-field check of each transaction
    always @(posedge clk) begin
        t_key_result want;
        int          g;
        if (!rst_n) begin
            m_ready <= 1'b0;
            rx_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_keys.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected transaction: data %04h", m_data);
                end else begin
                    want = expected_keys.pop_front();
                    if (m_data[7:0] !== want.char_code)
                        note_mismatch("char_code", want.char_code, m_data[7:0]);
                    if (m_data[13:8] !== want.flags)
                        note_mismatch("modifier_flags", {2'b00, want.flags},
                                      {2'b00, m_data[13:8]});
                    if (m_data[15:14] !== 2'b00)
                        note_mismatch("padding", 8'h00, {6'd0, m_data[15:14]});
                end
                g = draw_gap(rx_calm);
                rx_gap <= g;
                m_ready <= (g == 0);
                if ($urandom_range(0, 39) == 0)
                    rx_calm <= !rx_calm;
            end else if (rx_gap != 0) begin
                m_ready <= 1'b0;
                rx_gap <= rx_gap - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin
        logic [7:0] nav_codes [12];
        logic [7:0] mod_codes [4];
        logic [7:0] lock_codes [3];
        logic [7:0] chord;
        int         pick;
        int         stop_at;
        bit         esc;

        nav_codes = '{ps2s1_pkg::SC_HOME, ps2s1_pkg::SC_END, ps2s1_pkg::SC_UP,
                      ps2s1_pkg::SC_DOWN, ps2s1_pkg::SC_LEFT, ps2s1_pkg::SC_RIGHT,
                      ps2s1_pkg::SC_PGUP, ps2s1_pkg::SC_PGDN, ps2s1_pkg::SC_INS,
                      ps2s1_pkg::SC_DEL, ps2s1_pkg::SC_KP_ENTER, ps2s1_pkg::SC_KP_DIV};
        mod_codes = '{ps2s1_pkg::SC_LCTRL, ps2s1_pkg::SC_LSHIFT, ps2s1_pkg::SC_RSHIFT,
                      ps2s1_pkg::SC_LALT};
        lock_codes = '{ps2s1_pkg::SC_CAPS, ps2s1_pkg::SC_NUM, ps2s1_pkg::SC_SCROLL};

        // Directed: byte extremes, shift/caps/ctrl maps, prefix handling, locks
        scan_q.push_back(8'h00);
        scan_q.push_back(8'hFF);
        scan_q.push_back(ps2s1_pkg::SC_LSHIFT);
        scan_q.push_back(KEY_A);
        scan_q.push_back(KEY_SLASH);
        scan_q.push_back(ps2s1_pkg::SC_LSHIFT | BREAK_FLAG);
        scan_q.push_back(ps2s1_pkg::SC_CAPS);
        scan_q.push_back(KEY_A);
        scan_q.push_back(ps2s1_pkg::SC_RSHIFT);
        scan_q.push_back(KEY_A);
        scan_q.push_back(ps2s1_pkg::SC_RSHIFT | BREAK_FLAG);
        scan_q.push_back(ps2s1_pkg::SC_LCTRL);
        scan_q.push_back(KEY_SLASH);
        scan_q.push_back(ps2s1_pkg::SC_LCTRL | BREAK_FLAG);
        // double prefix, then keypad enter
        scan_q.push_back(ps2s1_pkg::SC_PREFIX);
        scan_q.push_back(ps2s1_pkg::SC_PREFIX);
        scan_q.push_back(ps2s1_pkg::SC_KP_ENTER & ~BREAK_FLAG);
        // right ctrl held over keypad divide, released with the escaped full byte
        scan_q.push_back(ps2s1_pkg::SC_PREFIX);
        scan_q.push_back(ps2s1_pkg::SC_RCTRL & ~BREAK_FLAG);
        scan_q.push_back(ps2s1_pkg::SC_PREFIX);
        scan_q.push_back(ps2s1_pkg::SC_KP_DIV & ~BREAK_FLAG);
        scan_q.push_back(ps2s1_pkg::SC_PREFIX);
        scan_q.push_back(ps2s1_pkg::SC_RCTRL);
        // escaped caps must not toggle
        scan_q.push_back(ps2s1_pkg::SC_PREFIX);
        scan_q.push_back(ps2s1_pkg::SC_CAPS);
        scan_q.push_back(ps2s1_pkg::SC_NUM);
        scan_q.push_back(ps2s1_pkg::SC_SCROLL);
        scan_q.push_back(ps2s1_pkg::SC_LALT);
        scan_q.push_back(ps2s1_pkg::SC_LALT | BREAK_FLAG);

        // Random: mostly well-formed key sequences, some raw noise
        stop_at = scan_q.size() + RANDOM_BYTES;
        while (scan_q.size() < stop_at) begin
            pick = $urandom_range(0, 9);
            esc = ($urandom_range(0, 4) == 0);
            if (pick <= 3) begin
                push_key(8'($urandom_range(0, KEY_LAST)), esc);
            end else if (pick <= 5) begin
                chord = mod_codes[2'($urandom_range(0, 3))];
                // only ctrl and alt have escaped right-hand versions
                if (chord == ps2s1_pkg::SC_LSHIFT || chord == ps2s1_pkg::SC_RSHIFT)
                    esc = 1'b0;
                if (esc)
                    scan_q.push_back(ps2s1_pkg::SC_PREFIX);
                scan_q.push_back(chord);
                repeat ($urandom_range(1, 4))
                    push_key(8'($urandom_range(0, KEY_LAST)), $urandom_range(0, 5) == 0);
                if (esc)
                    scan_q.push_back(ps2s1_pkg::SC_PREFIX);
                scan_q.push_back(chord | BREAK_FLAG);
            end else if (pick == 6) begin
                push_key(lock_codes[2'($urandom_range(0, 2))], esc);
            end else if (pick == 7) begin
                push_key(nav_codes[4'($urandom_range(0, 11))] & ~BREAK_FLAG, 1'b1);
            end else begin
                scan_q.push_back(8'($urandom_range(0, 255)));
            end
        end
        bytes_total = scan_q.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_sent != bytes_total || expected_keys.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_keys.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== ps2_scancode_set1_to_ascii.f =====
rtl/ps2s1_pkg.sv
rtl/ps2s1_xlate.sv
rtl/ps2_scancode_set1_to_ascii.sv
sim/ps2_scancode_set1_to_ascii_tb.sv
